@@ hw/rtl/ppls_pkg.sv @@
// shared types and constants of the palette pixel line streamer
// no dependencies; used by every module of the block

package ppls_pkg;

	// default sizes for the top level parameters and the queue depth
	localparam int PaletteEntriesDefault = 256;
	localparam int MaxDimensionDefault   = 1024;
	localparam int FifoDepth             = 4;

	// input item kinds carried in s_tuser
	localparam logic [1:0] FUNC_PAL_WRITE = 2'd0;
	localparam logic [1:0] FUNC_PIXEL     = 2'd1;
	localparam logic [1:0] FUNC_BLANK     = 2'd2;

	// display command bytes
	localparam logic [7:0] CMD_COLUMN   = 8'h2A;
	localparam logic [7:0] CMD_PAGE     = 8'h2B;
	localparam logic [7:0] CMD_MEMWRITE = 8'h2C;
	localparam logic [7:0] BYTE_MASK    = 8'hFF;

	// configuration register indexes
	localparam logic [1:0] CFG_X_START    = 2'd0;
	localparam logic [1:0] CFG_Y_START    = 2'd1;
	localparam logic [1:0] CFG_LINE_WIDTH = 2'd2;
	localparam logic [1:0] CFG_LINE_COUNT = 2'd3;

	// byte positions of one request on the output side
	localparam logic [3:0] POS_COLUMN   = 4'd0;
	localparam logic [3:0] POS_XS_HI    = 4'd1;
	localparam logic [3:0] POS_XS_LO    = 4'd2;
	localparam logic [3:0] POS_XE_HI    = 4'd3;
	localparam logic [3:0] POS_XE_LO    = 4'd4;
	localparam logic [3:0] POS_PAGE     = 4'd5;
	localparam logic [3:0] POS_YS_HI    = 4'd6;
	localparam logic [3:0] POS_YS_LO    = 4'd7;
	localparam logic [3:0] POS_YE_HI    = 4'd8;
	localparam logic [3:0] POS_YE_LO    = 4'd9;
	localparam logic [3:0] POS_MEMWRITE = 4'd10;
	localparam logic [3:0] POS_PIX_HI   = 4'd11;
	localparam logic [3:0] POS_PIX_LO   = 4'd12;

	// configuration registers
	typedef struct packed {
		logic [15:0] x_start;
		logic [15:0] y_start;
		logic [10:0] line_width;
		logic [10:0] line_count;
	} ppls_cfg_t;

	// one classified pixel request, front to back
	typedef struct packed {
		logic        hdr;
		logic [15:0] x_start;
		logic [15:0] x_end;
		logic [15:0] y_first;
		logic [15:0] y_end;
		logic [15:0] color;
	} ppls_entry_t;

	// queue handshake seen by the front
	typedef struct packed {
		logic push;
		logic ready;
	} ppls_push_t;

	// queue handshake seen by the back
	typedef struct packed {
		logic pop;
		logic valid;
	} ppls_pop_t;

endpackage

@@ hw/rtl/ppls_front.sv @@
// front part: accepts input requests, holds the colour store, keeps the
// column and row counters and classifies each pixel; uses ppls_pkg

module ppls_front #(
	parameter int PALETTE_ENTRIES = ppls_pkg::PaletteEntriesDefault,
	parameter int MAX_DIMENSION   = ppls_pkg::MaxDimensionDefault
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [23:0]           s_tdata,
	input  logic [1:0]            s_tuser,
	input  ppls_pkg::ppls_cfg_t   cfg,
	output ppls_pkg::ppls_push_t  push,
	input  logic                  push_ready,
	output ppls_pkg::ppls_entry_t push_data
);

	localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_DIMENSION);
	localparam int DW = $clog2(MAX_DIMENSION + 1);

	logic [7:0]    pixel_index;
	logic [15:0]   color_value;
	logic          accept;
	logic          in_range;
	logic          is_pixel;
	logic          pal_we;
	logic          s1_push;

	logic [DW-1:0] w_eff;
	logic [DW-1:0] h_eff;
	logic [DW-1:0] row_a;
	logic [DW-1:0] col_b;
	logic [DW-1:0] row_b;
	logic [DW-1:0] col_c;
	logic [DW-1:0] row_c;
	logic [15:0]   y_first;

	logic [CW-1:0] col_q;
	logic [CW-1:0] row_q;

	logic [15:0]   pal_mem [PALETTE_ENTRIES];

	logic          valid_s1;
	logic          use_pal_s1;
	logic          hdr_s1;
	logic [15:0]   pal_rd_s1;
	logic [15:0]   x_start_s1;
	logic [15:0]   x_end_s1;
	logic [15:0]   y_first_s1;
	logic [15:0]   y_end_s1;

	assign pixel_index = s_tdata[7:0];
	assign color_value = s_tdata[23:8];
	assign s_tready    = !valid_s1 || push_ready;
	assign accept      = s_tvalid && s_tready;
	assign in_range    = 9'(pixel_index) < 9'(PALETTE_ENTRIES);
	assign is_pixel    = (s_tuser == ppls_pkg::FUNC_PIXEL) || (s_tuser == ppls_pkg::FUNC_BLANK);
	assign pal_we      = accept && (s_tuser == ppls_pkg::FUNC_PAL_WRITE) && in_range;
	assign s1_push     = valid_s1 && push_ready;

	// effective frame size: zero counts as one, capped at the maximum
	always_comb begin
		if (cfg.line_width == '0) begin
			w_eff = DW'(1);
		end else if (32'(cfg.line_width) > 32'(MAX_DIMENSION)) begin
			w_eff = DW'(MAX_DIMENSION);
		end else begin
			w_eff = DW'(cfg.line_width);
		end
		if (cfg.line_count == '0) begin
			h_eff = DW'(1);
		end else if (32'(cfg.line_count) > 32'(MAX_DIMENSION)) begin
			h_eff = DW'(MAX_DIMENSION);
		end else begin
			h_eff = DW'(cfg.line_count);
		end
	end

	// counter update: wrap stale values after a size change, then step
	always_comb begin
		row_a = (DW'(row_q) >= h_eff) ? '0 : DW'(row_q);
		if (DW'(col_q) >= w_eff) begin
			col_b = '0;
			row_b = (row_a + DW'(1) >= h_eff) ? '0 : row_a + DW'(1);
		end else begin
			col_b = DW'(col_q);
			row_b = row_a;
		end
		if (col_b + DW'(1) >= w_eff) begin
			col_c = '0;
			row_c = (row_b + DW'(1) >= h_eff) ? '0 : row_b + DW'(1);
		end else begin
			col_c = col_b + DW'(1);
			row_c = row_b;
		end
		y_first = cfg.y_start + 16'(row_b);
	end

	// counters move only on pixel requests
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept && is_pixel) begin
			col_q <= CW'(col_c);
			row_q <= CW'(row_c);
		end
	end

	// colour store, written and read at one address per cycle
	always_ff @(posedge clk) begin
		if (pal_we) begin
			pal_mem[pixel_index[AW-1:0]] <= color_value;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_pixel) begin
			pal_rd_s1 <= pal_mem[pixel_index[AW-1:0]];
		end
	end

	// classified pixel register ahead of the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept && is_pixel) begin
			valid_s1 <= 1'b1;
		end else if (s1_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_pixel) begin
			use_pal_s1 <= (s_tuser == ppls_pkg::FUNC_PIXEL) && in_range;
			hdr_s1     <= (col_b == '0);
			x_start_s1 <= cfg.x_start;
			x_end_s1   <= cfg.x_start + 16'(w_eff) - 16'd1;
			y_first_s1 <= y_first;
			y_end_s1   <= y_first + 16'(h_eff) - 16'd1;
		end
	end

	// queue entry
	always_comb begin
		push.push         = s1_push;
		push.ready        = push_ready;
		push_data.hdr     = hdr_s1;
		push_data.x_start = x_start_s1;
		push_data.x_end   = x_end_s1;
		push_data.y_first = y_first_s1;
		push_data.y_end   = y_end_s1;
		push_data.color   = use_pal_s1 ? pal_rd_s1 : 16'd0;
	end

endmodule

@@ hw/rtl/ppls_fifo.sv @@
// short show-ahead queue of classified pixel requests between the parts
// uses ppls_pkg for the entry type

module ppls_fifo #(
	parameter int DEPTH = ppls_pkg::FifoDepth
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ppls_pkg::ppls_push_t  push,
	input  ppls_pkg::ppls_entry_t push_data,
	output logic                  push_ready,
	input  ppls_pkg::ppls_pop_t   pop,
	output logic                  pop_valid,
	output ppls_pkg::ppls_entry_t pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	ppls_pkg::ppls_entry_t slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = count_q != NW'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push.push && push_ready;
	assign do_pop     = pop.pop && pop_valid;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + NW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

endmodule

@@ hw/rtl/ppls_back.sv @@
// back part: walks the bytes of each queued pixel request, header first
// when due, into the output register; uses ppls_pkg

module ppls_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pop_valid,
	input  ppls_pkg::ppls_entry_t pop_data,
	output ppls_pkg::ppls_pop_t   pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,
	output logic                  m_tuser,
	output logic                  m_tlast
);

	logic [3:0] pos_q;
	logic       started_q;
	logic [3:0] pos;
	logic       emit;
	logic [7:0] byte_d;
	logic       data_d;

	assign pos  = started_q ? pos_q :
	              (pop_data.hdr ? ppls_pkg::POS_COLUMN : ppls_pkg::POS_PIX_HI);
	assign emit = pop_valid && (!m_tvalid || m_tready);

	// byte select for the current position
	always_comb begin
		data_d = 1'b1;
		unique case (pos)
			ppls_pkg::POS_COLUMN: begin
				byte_d = ppls_pkg::CMD_COLUMN;
				data_d = 1'b0;
			end
			ppls_pkg::POS_XS_HI: byte_d = pop_data.x_start[15:8];
			ppls_pkg::POS_XS_LO: byte_d = pop_data.x_start[7:0] & ppls_pkg::BYTE_MASK;
			ppls_pkg::POS_XE_HI: byte_d = pop_data.x_end[15:8];
			ppls_pkg::POS_XE_LO: byte_d = pop_data.x_end[7:0];
			ppls_pkg::POS_PAGE: begin
				byte_d = ppls_pkg::CMD_PAGE;
				data_d = 1'b0;
			end
			ppls_pkg::POS_YS_HI: byte_d = pop_data.y_first[15:8];
			ppls_pkg::POS_YS_LO: byte_d = pop_data.y_first[7:0];
			ppls_pkg::POS_YE_HI: byte_d = pop_data.y_end[15:8];
			ppls_pkg::POS_YE_LO: byte_d = pop_data.y_end[7:0];
			ppls_pkg::POS_MEMWRITE: begin
				byte_d = ppls_pkg::CMD_MEMWRITE;
				data_d = 1'b0;
			end
			ppls_pkg::POS_PIX_HI: byte_d = pop_data.color[15:8];
			default: byte_d = pop_data.color[7:0];
		endcase
	end

	// position sequencer; the queue entry is released on its last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= ppls_pkg::POS_COLUMN;
			started_q <= 1'b0;
		end else if (emit) begin
			if (pos == ppls_pkg::POS_PIX_LO) begin
				started_q <= 1'b0;
			end else begin
				pos_q     <= pos + 4'd1;
				started_q <= 1'b1;
			end
		end
	end

	assign pop.pop   = emit && (pos == ppls_pkg::POS_PIX_LO);
	assign pop.valid = pop_valid;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (emit) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_tdata <= byte_d;
			m_tuser <= data_d;
			m_tlast <= (pos == ppls_pkg::POS_PIX_LO);
		end
	end

endmodule

@@ hw/rtl/palette_pixel_line_streamer.sv @@
// top level of the palette pixel line streamer: configuration registers,
// front part, request queue and back part; uses ppls_pkg

// Turns 8-bit palette indices into an RGB565 byte stream for a serial
// display, one byte per cycle on the master side while bytes are queued
// and m_tready does not stall, with tuser as the data/command flag and
// tlast on the last byte of each pixel. The first pixel of each row
// carries the column, page and memory-write header ahead of its two
// colour bytes. The output is a one-byte-wide register fed from the back
// part's byte sequencer. Palette writes give no bytes; the colour store
// is one write and one registered read port. A four-entry queue between
// front and back lets the front keep accepting pixels while a header goes
// out, and the output register holds each byte steady until it is taken.

module palette_pixel_line_streamer #(
	parameter int PALETTE_ENTRIES = ppls_pkg::PaletteEntriesDefault,
	parameter int MAX_DIMENSION   = ppls_pkg::MaxDimensionDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // pixel_index [7:0], color_value [23:8]
	input  logic [1:0]  s_tuser,   // func [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_byte [7:0]
	output logic        m_tuser,   // is_data [0]
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	ppls_pkg::ppls_cfg_t   cfg_q;
	ppls_pkg::ppls_push_t  push;
	ppls_pkg::ppls_entry_t push_data;
	ppls_pkg::ppls_pop_t   pop;
	ppls_pkg::ppls_entry_t pop_data;
	logic                  push_ready;
	logic                  pop_valid;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_start    <= 16'd0;
			cfg_q.y_start    <= 16'd0;
			cfg_q.line_width <= 11'd256;
			cfg_q.line_count <= 11'd240;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ppls_pkg::CFG_X_START:    cfg_q.x_start    <= cfg_wdata;
				ppls_pkg::CFG_Y_START:    cfg_q.y_start    <= cfg_wdata;
				ppls_pkg::CFG_LINE_WIDTH: cfg_q.line_width <= cfg_wdata[10:0];
				default:                  cfg_q.line_count <= cfg_wdata[10:0];
			endcase
		end
	end

	ppls_front #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES),
		.MAX_DIMENSION  (MAX_DIMENSION)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg       (cfg_q),
		.push      (push),
		.push_ready(push_ready),
		.push_data (push_data)
	);

	ppls_fifo #(
		.DEPTH(ppls_pkg::FifoDepth)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.push_ready(push_ready),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_data  (pop_data)
	);

	ppls_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_data (pop_data),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

@@ hw/rtl/ppls_checker.sv @@
// port-level checks of the palette pixel line streamer, bound to the top
// level; uses ppls_pkg for the command codes

module ppls_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	// a stalled byte stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output byte withdrawn while stalled");

	// a stalled byte keeps its value and flags
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
		else $error("output byte changed while stalled");

	// every request ends on a colour byte
	a_last_is_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser)
		else $error("last byte flagged as command");

	// command bytes are only the three header commands and never end a request
	a_cmd_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> !m_tlast && (m_tdata == ppls_pkg::CMD_COLUMN ||
			m_tdata == ppls_pkg::CMD_PAGE || m_tdata == ppls_pkg::CMD_MEMWRITE))
		else $error("bad command byte");

	// the memory-write command is followed at once by the colour bytes
	a_memwrite_follow: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tuser && m_tdata == ppls_pkg::CMD_MEMWRITE
		|=> m_tvalid && m_tuser && !m_tlast)
		else $error("no colour byte after memory-write command");

endmodule

bind palette_pixel_line_streamer ppls_checker u_checker (.*);
